// File: hdl/multi_channel_pulse_width_capture_top_defines.svh
// ----------------------------------------------------------------------------
// Pulse width capture assertion macros
// Shared concurrent assertion helpers for the capture block.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH
`define MULTI_CHANNEL_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH

// same-cycle implication
`define MCPWC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcpwc assertion failed");

// next-cycle implication
`define MCPWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcpwc assertion failed");

`endif

// File: hdl/mcpwc_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width capture package
// Widths, reset values and the lane-to-merge transaction type.
// ----------------------------------------------------------------------------
package mcpwc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = 3;
    localparam int TS_W     = 16;

    localparam logic [CHANNELS-1:0] MASK_RESET   = 8'hFF;
    localparam logic [TS_W-1:0]     PERIOD_RESET = 16'd4001;

    typedef logic [CHANNELS-1:0] t_chmask;
    typedef logic [TS_W-1:0]     t_stamp;
    typedef logic [CH_W-1:0]     t_chan;

    typedef struct packed {
        t_chmask                     done;
        logic [CHANNELS-1:0][TS_W-1:0] width;
    } t_batch;

endpackage

// File: hdl/mcpwc_if.sv
// ----------------------------------------------------------------------------
// Pulse width capture channel interfaces
// Valid/ready streams for edge events and completed widths.
// ----------------------------------------------------------------------------
interface mcpwc_in_if;
    import mcpwc_pkg::*;

    logic    valid;
    logic    ready;
    t_stamp  timer_count;
    t_chmask edge_flags;

    modport source (output valid, output timer_count, output edge_flags, input ready);
    modport sink   (input valid, input timer_count, input edge_flags, output ready);
endinterface

interface mcpwc_out_if;
    import mcpwc_pkg::*;

    logic   valid;
    logic   ready;
    t_chan  channel;
    t_stamp pulse_width;
    logic   last;

    modport source (output valid, output channel, output pulse_width, output last,
                    input ready);
    modport sink   (input valid, input channel, input pulse_width, input last,
                    output ready);
endinterface

// File: hdl/mcpwc_lane.sv
// ----------------------------------------------------------------------------
// Pulse width capture lane
// Per-channel edge state, rise stamp and width computation.
// ----------------------------------------------------------------------------
module mcpwc_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_hit,
    input  mcpwc_pkg::t_stamp i_now,
    input  mcpwc_pkg::t_stamp i_period,
    output logic             o_done,
    output mcpwc_pkg::t_stamp o_width
);
    import mcpwc_pkg::*;

    logic   r_await;
    logic   r_done;
    t_stamp r_rise;
    t_stamp r_width;
    t_stamp n_width;

    always_comb begin
        if (r_rise > i_now) begin
            n_width = i_period - r_rise + i_now;
        end else begin
            n_width = i_now - r_rise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_done <= i_hit && r_await;
            if (i_hit) begin
                r_await <= ~r_await;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_hit) begin
            if (r_await) begin
                r_width <= n_width;
            end else begin
                r_rise <= i_now;
            end
        end
    end

    assign o_done  = r_done;
    assign o_width = r_width;

endmodule

// File: hdl/mcpwc_merge.sv
// ----------------------------------------------------------------------------
// Pulse width capture merge
// Serializes completed lane widths in channel order, marks the last one.
// ----------------------------------------------------------------------------
module mcpwc_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_batch_valid,
    input  mcpwc_pkg::t_batch i_batch,
    output logic              o_take,
    mcpwc_out_if.source       m_out
);
    import mcpwc_pkg::*;

    t_chmask r_pend;
    t_stamp  r_wid [CHANNELS];
    logic    r_ovalid;
    t_chan   r_ochan;
    t_stamp  r_owidth;
    logic    r_olast;

    t_chan   pick;
    t_chmask pick_bit;
    t_chmask pend_after;
    logic    out_free;
    logic    pop;

    always_comb begin
        pick     = '0;
        pick_bit = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (r_pend[c]) begin
                pick     = t_chan'(c);
                pick_bit = t_chmask'(1) << c;
            end
        end
    end

    assign out_free   = !r_ovalid || m_out.ready;
    assign pop        = out_free && (r_pend != '0);
    assign pend_after = pop ? (r_pend & ~pick_bit) : r_pend;
    assign o_take     = i_batch_valid && (pend_after == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= o_take ? i_batch.done : pend_after;
            if (pop) begin
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_wid[c] <= i_batch.width[c];
            end
        end
        if (pop) begin
            r_ochan  <= pick;
            r_owidth <= r_wid[pick];
            r_olast  <= (pend_after == '0);
        end
    end

    assign m_out.valid       = r_ovalid;
    assign m_out.channel     = r_ochan;
    assign m_out.pulse_width = r_owidth;
    assign m_out.last        = r_olast;

endmodule

// File: hdl/multi_channel_pulse_width_capture_top.sv
// ----------------------------------------------------------------------------
// Multi-channel pulse width capture
// Eight capture lanes measure high times; a merge stage emits them in order.
//
//   channel   dir   payload                          transaction
//   s_in      in    timer_count, edge_flags          valid & ready
//   m_out     out   channel, pulse_width, last       valid & ready
//   apb       in    channel_mask @0x0, timer_period @0x4   psel & penable & pwrite
//
// An event is accepted on valid & ready; all lanes update in parallel into
// a lane register. The merge stage emits one width per cycle while m_out
// is ready, and the next event is accepted while an event's widths
// drain. Events with no completed pulse emit no width. Reset clears edge
// state at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "multi_channel_pulse_width_capture_top_defines.svh"

module multi_channel_pulse_width_capture_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcpwc_in_if.sink    s_in,
    mcpwc_out_if.source m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcpwc_pkg::*;

    localparam logic REG_MASK   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    t_chmask r_mask;
    t_stamp  r_period;
    logic    r_a_valid;

    logic    accept;
    logic    take;
    logic    cfg_wr;
    t_batch  batch;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= MASK_RESET;
            r_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MASK:   r_mask   <= pwdata[CHANNELS-1:0];
                REG_PERIOD: r_period <= pwdata[TS_W-1:0];
                default:    r_mask   <= r_mask;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MASK:   prdata = {{(32-CHANNELS){1'b0}}, r_mask};
            REG_PERIOD: prdata = {{(32-TS_W){1'b0}}, r_period};
            default:    prdata = '0;
        endcase
    end

    assign s_in.ready = !r_a_valid || take;
    assign accept     = s_in.valid && s_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (take) begin
            r_a_valid <= 1'b0;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        mcpwc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (accept),
            .i_hit    (s_in.edge_flags[c] && r_mask[c]),
            .i_now    (s_in.timer_count),
            .i_period (r_period),
            .o_done   (batch.done[c]),
            .o_width  (batch.width[c])
        );
    end

    mcpwc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch_valid (r_a_valid),
        .i_batch       (batch),
        .o_take        (take),
        .m_out         (m_out)
    );

    // widths of one event follow each other without a gap, in rising channel order
    `MCPWC_ASSERT_NXT(a_burst_gapless, i_clk, i_rst_n, m_out.valid && m_out.ready && !m_out.last, m_out.valid)
    `MCPWC_ASSERT_NXT(a_burst_order, i_clk, i_rst_n, m_out.valid && m_out.ready && !m_out.last, m_out.channel > $past(m_out.channel))
    // a held lane register that merge does not take blocks the input
    `MCPWC_ASSERT_NOW(a_lane_hold, i_clk, i_rst_n, r_a_valid && !take, !s_in.ready)

endmodule

// File: bench/tb_mcpwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width capture bench constants
// Register byte addresses shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package tb_mcpwc_pkg;

    localparam logic [2:0] ADDR_CHANNEL_MASK = 3'd0;
    localparam logic [2:0] ADDR_TIMER_PERIOD = 3'd4;

endpackage

// File: bench/mcpwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width capture checker
// Watches the event stream and the register port, tracks per-channel edge
// state, predicts every completed width and compares each result
// transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
module mcpwc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  mcpwc_pkg::t_stamp i_timer_count,
    input  mcpwc_pkg::t_chmask i_edge_flags,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  mcpwc_pkg::t_chan  i_out_channel,
    input  mcpwc_pkg::t_stamp i_out_width,
    input  logic              i_out_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    import mcpwc_pkg::*;
    import tb_mcpwc_pkg::*;

    typedef struct packed {
        t_chan  channel;
        t_stamp width;
        logic   last;
    } t_width_rec;

    t_width_rec widths_due[$];
    t_chmask    mask_r;
    t_stamp     period_r;
    t_chmask    armed;
    t_stamp     rise_at [CHANNELS];
    int         errors = 0;

    task automatic flag_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic capture_edges(input t_stamp now, input t_chmask flags);
        t_chmask    hit;
        t_stamp     w;
        t_width_rec found[$];
        hit = flags & mask_r;
        for (int c = 0; c < CHANNELS; c++) begin
            if (hit[c]) begin
                if (!armed[c]) begin
                    rise_at[c] = now;
                    armed[c]   = 1'b1;
                end else begin
                    // timer wrapped between rise and fall
                    if (rise_at[c] > now) begin
                        w = period_r - rise_at[c] + now;
                    end else begin
                        w = now - rise_at[c];
                    end
                    armed[c] = 1'b0;
                    found.push_back(t_width_rec'{channel: t_chan'(c), width: w,
                                                 last: 1'b0});
                end
            end
        end
        if (found.size() > 0) begin
            found[found.size()-1].last = 1'b1;
        end
        foreach (found[i]) begin
            widths_due.push_back(found[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_width_rec want;
        if (!i_rst_n) begin
            mask_r   = MASK_RESET;
            period_r = PERIOD_RESET;
            armed    = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                rise_at[c] = '0;
            end
            widths_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_CHANNEL_MASK: mask_r   = pwdata[CHANNELS-1:0];
                    ADDR_TIMER_PERIOD: period_r = pwdata[TS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                capture_edges(i_timer_count, i_edge_flags);
            end
            if (i_out_valid && i_out_ready) begin
                if (widths_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction ch=%0d width=%0d last=%0b",
                                            i_out_channel, i_out_width, i_out_last));
                end else begin
                    want = widths_due.pop_front();
                    if (i_out_channel !== want.channel) begin
                        flag_mismatch($sformatf("channel %0d, expected %0d",
                                                i_out_channel, want.channel));
                    end
                    if (i_out_width !== want.width) begin
                        flag_mismatch($sformatf("ch %0d width %0d, expected %0d",
                                                want.channel, i_out_width, want.width));
                    end
                    if (i_out_last !== want.last) begin
                        flag_mismatch($sformatf("ch %0d last %0b, expected %0b",
                                                want.channel, i_out_last, want.last));
                    end
                end
            end
        end
        o_pending    <= widths_due.size();
        o_fail_count <= errors;
    end

endmodule

// File: bench/tb_multi_channel_pulse_width_capture_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse width capture testbench
// Drives edge events and register writes into the capture block under
// several mask and period settings, with random idling on both streams,
// and takes the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_multi_channel_pulse_width_capture_top;
    import mcpwc_pkg::*;
    import tb_mcpwc_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int     src_idle_pct  = 27;
    int     sink_idle_pct = 53;
    int     fail_count;
    int     pending;
    int     cycles = 0;
    t_stamp last_stamp = '0;

    mcpwc_in_if  in_if ();
    mcpwc_out_if out_if ();

    multi_channel_pulse_width_capture_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mcpwc_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_timer_count (in_if.timer_count),
        .i_edge_flags  (in_if.edge_flags),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_channel (out_if.channel),
        .i_out_width   (out_if.pulse_width),
        .i_out_last    (out_if.last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_event(input t_stamp ts, input t_chmask flags);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.timer_count <= ts;
        in_if.edge_flags  <= flags;
        last_stamp         = ts;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        t_stamp  ts;
        t_chmask flags;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                ts = t_stamp'($urandom);
            end else begin
                ts = last_stamp + t_stamp'($urandom_range(0, 3000));
            end
            case ($urandom_range(0, 3))
                0:       flags = t_chmask'(1 << $urandom_range(0, CHANNELS - 1));
                1:       flags = '1;
                default: flags = t_chmask'($urandom);
            endcase
            send_event(ts, flags);
        end
    endtask

    // drop valid, let every width come out, then cover in-flight empty events
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.timer_count = '0;
        in_if.edge_flags  = '0;
        out_if.ready      = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: mask all on, period 4001
        send_event(16'd0,     8'h00);
        send_event(16'd0,     8'h01);
        send_event(16'hFFFF,  8'h01);
        send_event(16'd100,   8'hFF);
        send_event(16'd50,    8'hFF);
        send_event(16'hFFFF,  8'h80);
        send_event(16'd0,     8'h80);
        send_event(16'd1234,  8'h02);
        send_event(16'd1234,  8'h02);
        send_event(16'd10,    8'hAA);
        send_event(16'd20,    8'h55);
        send_event(16'd30,    8'hFF);
        send_event(16'd7,     8'h3C);
        send_event(16'd9,     8'h24);
        send_event(16'd9,     8'h18);
        send_random(60);
        settle();

        reg_write(ADDR_CHANNEL_MASK, 32'h0000_0000);
        reg_write(ADDR_TIMER_PERIOD, 32'd1);
        send_random(15);
        settle();

        reg_write(ADDR_CHANNEL_MASK, 32'h0000_000F);
        reg_write(ADDR_TIMER_PERIOD, 32'd65535);
        send_event(16'd5,   8'hF0);
        send_event(16'd600, 8'hF0);
        send_random(60);
        settle();

        src_idle_pct  = 53;
        sink_idle_pct = 27;
        reg_write(ADDR_CHANNEL_MASK, 32'h0000_00FF);
        reg_write(ADDR_TIMER_PERIOD, 32'd0);
        // whichever pair closes on ch0, it wraps
        send_event(16'd500, 8'h01);
        send_event(16'd100, 8'h01);
        send_event(16'd40,  8'h01);
        send_random(70);
        settle();

        reg_write(ADDR_CHANNEL_MASK, $urandom);
        reg_write(ADDR_TIMER_PERIOD, $urandom);
        send_random(70);
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        reg_write(ADDR_CHANNEL_MASK, 32'h0000_00A5);
        reg_write(ADDR_TIMER_PERIOD, 32'd1);
        send_random(70);
        settle();

        reg_write(ADDR_CHANNEL_MASK, 32'h0000_00FF);
        reg_write(ADDR_TIMER_PERIOD, 32'd4001);
        send_random(85);
        settle();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mcpwc_pkg.sv
hdl/mcpwc_if.sv
hdl/mcpwc_lane.sv
hdl/mcpwc_merge.sv
hdl/multi_channel_pulse_width_capture_top.sv
bench/tb_mcpwc_pkg.sv
bench/mcpwc_checker.sv
bench/tb_multi_channel_pulse_width_capture_top.sv
